### sv/cree_pkg.sv
// types, codes and reset constants shared by the role election engine
package cree_pkg;

   typedef enum logic [1:0] {
      ROLE_FOLLOWER  = 2'd0,
      ROLE_CANDIDATE = 2'd1,
      ROLE_LEADER    = 2'd2
   } cree_role_type;

   // event codes
   localparam logic [2:0] MODE_TICK       = 3'd0;
   localparam logic [2:0] MODE_VOTE_REQ   = 3'd1;
   localparam logic [2:0] MODE_APPEND_REQ = 3'd2;
   localparam logic [2:0] MODE_VOTE_RSP   = 3'd3;
   localparam logic [2:0] MODE_CLIENT     = 3'd4;

   // result codes
   localparam logic [2:0] KIND_NONE        = 3'd0;
   localparam logic [2:0] KIND_VOTE_REPLY  = 3'd1;
   localparam logic [2:0] KIND_APPEND_RPLY = 3'd2;
   localparam logic [2:0] KIND_VOTE_BCAST  = 3'd3;
   localparam logic [2:0] KIND_HEARTBEAT   = 3'd4;
   localparam logic [2:0] KIND_CLIENT_RSLT = 3'd5;

   // register indexes
   localparam logic [2:0] CSR_NODE_ID      = 3'd0;
   localparam logic [2:0] CSR_PEER_COUNT   = 3'd1;
   localparam logic [2:0] CSR_HEARTBEAT    = 3'd2;
   localparam logic [2:0] CSR_TIMEOUT_MIN  = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT_SPAN = 3'd4;
   localparam logic [2:0] CSR_RANDOM_SEED  = 3'd5;

   // register reset values
   localparam logic [7:0]  RST_NODE_ID      = 8'd0;
   localparam logic [3:0]  RST_PEER_COUNT   = 4'd2;
   localparam logic [15:0] RST_HEARTBEAT    = 16'd50;
   localparam logic [15:0] RST_TIMEOUT_MIN  = 16'd150;
   localparam logic [15:0] RST_TIMEOUT_SPAN = 16'd150;
   localparam logic [15:0] RST_RANDOM_SEED  = 16'd1;

   localparam int REQ_DATA_BITS = 112;
   localparam int RSP_DATA_BITS = 176;

   typedef struct packed {
      logic [7:0]  node_id;
      logic [3:0]  peer_count;
      logic [15:0] heartbeat_interval;
      logic [15:0] timeout_min;
      logic [15:0] timeout_span;
      logic [15:0] random_seed;
   } cree_cfg_type;

   typedef struct packed {
      cree_role_type role;
      logic [31:0]   term;
      logic          vote_valid;
      logic [7:0]    vote_id;
      logic [16:0]   elapsed;
      logic [16:0]   timeout;
      logic [15:0]   lfsr;
      logic [3:0]    votes_won;
      logic [3:0]    answers_seen;
      logic [31:0]   last_index;
      logic [31:0]   last_term;
      logic [31:0]   commit;
   } cree_state_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] msg_term;
      logic [7:0]  sender_id;
      logic [31:0] sender_last_index;
      logic [31:0] sender_last_term;
      logic        granted;
   } cree_event_type;

   typedef struct packed {
      logic [2:0]        msg_kind;
      logic [31:0]       reply_term;
      logic              ok;
      logic [31:0]       log_index;
      logic [31:0]       log_term;
      logic [31:0]       commit_point;
      logic [1:0]        role;
      logic [31:0]       term_now;
      logic signed [8:0] vote_holder;
   } cree_result_type;

endpackage

### sv/cree_timeout.sv
// lfsr step and scaling of the random election timeout into its window
module cree_timeout (
   input  logic [15:0] lfsr,
   input  logic [15:0] timeout_min,
   input  logic [15:0] timeout_span,
   output logic [15:0] lfsr_next,
   output logic [16:0] timeout_next
);
   logic        feedback;
   logic [32:0] scaled;

   assign feedback  = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
   assign lfsr_next = {feedback, lfsr[15:1]};

   // next lfsr value * (span + 1), top bits select a point in the window
   assign scaled       = 33'(lfsr_next) * 33'({1'b0, timeout_span} + 17'd1);
   assign timeout_next = {1'b0, timeout_min} + scaled[32:16];
endmodule

### sv/cree_event.sv
// next state and result for one event
module cree_event #(
   parameter int MAX_PEERS = 8,
   parameter int TERM_BITS = 32
) (
   input  cree_pkg::cree_state_type  cur,
   input  cree_pkg::cree_cfg_type    cfg,
   input  cree_pkg::cree_event_type  ev,
   output cree_pkg::cree_state_type  nxt,
   output cree_pkg::cree_result_type res
);
   import cree_pkg::*;

   localparam logic [31:0] TermMax =
      (TERM_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << TERM_BITS) - 64'd1);
   localparam logic [3:0] MaxPeersW = 4'(MAX_PEERS);

   logic [15:0] lfsr_step;
   logic [16:0] timeout_new;
   logic [3:0]  peers_used;
   logic [4:0]  quorum;

   cree_timeout u_timeout (
      .lfsr         (cur.lfsr),
      .timeout_min  (cfg.timeout_min),
      .timeout_span (cfg.timeout_span),
      .lfsr_next    (lfsr_step),
      .timeout_next (timeout_new)
   );

   assign peers_used = (cfg.peer_count > MaxPeersW) ? MaxPeersW : cfg.peer_count;
   assign quorum     = 5'(({1'b0, peers_used} + 5'd1) >> 1) + 5'd1;

   always_comb begin
      logic [31:0] mt;
      logic [16:0] elapsed_inc;
      logic [3:0]  answers_inc;
      logic [3:0]  votes_inc;
      logic [2:0]  kind;
      logic        ok;
      logic        is_reply;
      logic        fresh;

      nxt         = cur;
      kind        = KIND_NONE;
      ok          = 1'b0;
      is_reply    = 1'b0;
      fresh       = 1'b0;
      mt          = (ev.msg_term > TermMax) ? TermMax : ev.msg_term;
      elapsed_inc = (cur.elapsed == '1) ? cur.elapsed : cur.elapsed + 17'd1;
      answers_inc = (cur.answers_seen == '1) ? cur.answers_seen : cur.answers_seen + 4'd1;
      votes_inc   = (ev.granted && cur.votes_won != '1) ? cur.votes_won + 4'd1 : cur.votes_won;

      case (ev.mode)
         MODE_TICK: begin
            nxt.elapsed = elapsed_inc;
            if (cur.role == ROLE_LEADER) begin
               if (elapsed_inc >= {1'b0, cfg.heartbeat_interval}) begin
                  kind        = KIND_HEARTBEAT;
                  nxt.elapsed = '0;
               end
            end else if (elapsed_inc >= cur.timeout) begin
               // start an election
               nxt.role = ROLE_CANDIDATE;
               if (cur.term < TermMax) begin
                  nxt.term = cur.term + 32'd1;
               end
               nxt.vote_valid   = 1'b1;
               nxt.vote_id      = cfg.node_id;
               nxt.lfsr         = lfsr_step;
               nxt.elapsed      = '0;
               nxt.timeout      = timeout_new;
               nxt.votes_won    = 4'd1;
               nxt.answers_seen = '0;
               if (quorum == 5'd1) begin
                  nxt.role = ROLE_LEADER;
                  kind     = KIND_HEARTBEAT;
               end else begin
                  kind = KIND_VOTE_BCAST;
               end
            end
         end
         MODE_VOTE_REQ: begin
            kind     = KIND_VOTE_REPLY;
            is_reply = 1'b1;
            if (mt >= cur.term) begin
               if (mt > cur.term) begin
                  nxt.term       = mt;
                  nxt.role       = ROLE_FOLLOWER;
                  nxt.vote_valid = 1'b0;
                  nxt.vote_id    = '0;
               end
               fresh = (ev.sender_last_term > cur.last_term) ||
                       (ev.sender_last_term == cur.last_term &&
                        ev.sender_last_index >= cur.last_index);
               if ((!nxt.vote_valid || nxt.vote_id == ev.sender_id) && fresh) begin
                  nxt.vote_valid = 1'b1;
                  nxt.vote_id    = ev.sender_id;
                  ok             = 1'b1;
                  nxt.lfsr       = lfsr_step;
                  nxt.elapsed    = '0;
                  nxt.timeout    = timeout_new;
               end
            end
         end
         MODE_APPEND_REQ: begin
            kind     = KIND_APPEND_RPLY;
            is_reply = 1'b1;
            if (mt >= cur.term) begin
               if (mt > cur.term) begin
                  nxt.term       = mt;
                  nxt.vote_valid = 1'b0;
                  nxt.vote_id    = '0;
               end
               nxt.role    = ROLE_FOLLOWER;
               nxt.lfsr    = lfsr_step;
               nxt.elapsed = '0;
               nxt.timeout = timeout_new;
               ok          = 1'b1;
            end
         end
         MODE_VOTE_RSP: begin
            if (mt > cur.term) begin
               nxt.term       = mt;
               nxt.role       = ROLE_FOLLOWER;
               nxt.vote_valid = 1'b0;
               nxt.vote_id    = '0;
            end else if (cur.role == ROLE_CANDIDATE && mt == cur.term) begin
               nxt.answers_seen = answers_inc;
               nxt.votes_won    = votes_inc;
               if ({1'b0, votes_inc} >= quorum) begin
                  nxt.role    = ROLE_LEADER;
                  nxt.elapsed = '0;
                  kind        = KIND_HEARTBEAT;
               end else if (answers_inc >= peers_used) begin
                  nxt.role = ROLE_FOLLOWER;
               end
            end
         end
         MODE_CLIENT: begin
            kind = KIND_CLIENT_RSLT;
            if (cur.role == ROLE_LEADER && cur.last_index != '1) begin
               nxt.last_index = cur.last_index + 32'd1;
               nxt.last_term  = cur.term;
               nxt.commit     = cur.last_index + 32'd1;
               ok             = 1'b1;
            end
         end
         default: begin
         end
      endcase

      res.msg_kind     = kind;
      res.reply_term   = is_reply ? cur.term : nxt.term;
      res.ok           = ok;
      res.log_index    = nxt.last_index;
      res.log_term     = nxt.last_term;
      res.commit_point = nxt.commit;
      res.role         = nxt.role;
      res.term_now     = nxt.term;
      res.vote_holder  = nxt.vote_valid ? $signed({1'b0, nxt.vote_id}) : -9'sd1;
   end
endmodule

### sv/consensus_role_election_engine.sv
// top level of the role, term and vote engine of one consensus replica
module consensus_role_election_engine #(
   parameter int MAX_PEERS = 8,
   parameter int TERM_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // event transactions
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // msg_term[31:0], sender_id[39:32], sender_last_index[71:40],
   // sender_last_term[103:72], granted[104], zero fill
   input  logic [cree_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // mode[2:0]
   input  logic [2:0]                             req_tuser,
   // result transactions
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // reply_term[31:0], ok[32], log_index[64:33], log_term[96:65],
   // commit_point[128:97], role[130:129], term_now[162:131],
   // vote_holder[171:163], zero fill
   output logic [cree_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   // msg_kind[2:0]
   output logic [2:0]                             rsp_tuser,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [2:0]                             csr_index,
   input  logic [15:0]                            csr_data
);
   // One event per clock cycle, sustained while rsp_tready is high. An accepted
   // event is held in the input register, then the event logic (compares, a
   // saturating term update and the 16x17 multiply that scales the lfsr into
   // the timeout window) updates the replica state and loads the result
   // register in a single step, so a result is on the output once its event
   // has moved on from the input register, and it stays there until taken;
   // every event gives exactly one result. The result register parts the two
   // sides: a new event is taken into an empty input register while a finished
   // result still waits, and back-pressure stalls only the event in the input
   // register. Register writes are held off while an event sits in the input
   // register and belong in idle periods; a write of random_seed also reloads
   // the lfsr (a zero seed loads one). peer_count above MAX_PEERS is treated
   // as MAX_PEERS, and incoming terms are clamped to TERM_BITS bits.
   import cree_pkg::*;

   logic            in_valid_ff;
   cree_event_type  in_event_ff;
   logic            out_valid_ff;
   cree_result_type out_result_ff;
   cree_state_type  state_ff;
   cree_state_type  state_in;
   cree_result_type result_in;
   cree_cfg_type    cfg_ff;
   cree_event_type  req_event;
   logic            advance;
   logic            req_take;
   logic            csr_take;

   // field split of the incoming transaction
   assign req_event.mode              = req_tuser;
   assign req_event.msg_term          = req_tdata[31:0];
   assign req_event.sender_id         = req_tdata[39:32];
   assign req_event.sender_last_index = req_tdata[71:40];
   assign req_event.sender_last_term  = req_tdata[103:72];
   assign req_event.granted           = req_tdata[104];

   // input register moves on when the result register is free or drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   // no write while an event is about to update the state
   assign csr_ready  = !in_valid_ff;
   assign csr_take   = csr_valid && csr_ready;

   cree_event #(
      .MAX_PEERS (MAX_PEERS),
      .TERM_BITS (TERM_BITS)
   ) u_event (
      .cur (state_ff),
      .cfg (cfg_ff),
      .ev  (in_event_ff),
      .nxt (state_in),
      .res (result_in)
   );

   // control, state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff.node_id            <= RST_NODE_ID;
         cfg_ff.peer_count         <= RST_PEER_COUNT;
         cfg_ff.heartbeat_interval <= RST_HEARTBEAT;
         cfg_ff.timeout_min        <= RST_TIMEOUT_MIN;
         cfg_ff.timeout_span       <= RST_TIMEOUT_SPAN;
         cfg_ff.random_seed        <= RST_RANDOM_SEED;
         state_ff.role         <= ROLE_FOLLOWER;
         state_ff.term         <= '0;
         state_ff.vote_valid   <= 1'b0;
         state_ff.vote_id      <= '0;
         state_ff.elapsed      <= '0;
         state_ff.timeout      <= {1'b0, RST_TIMEOUT_MIN};
         state_ff.lfsr         <= RST_RANDOM_SEED;
         state_ff.votes_won    <= '0;
         state_ff.answers_seen <= '0;
         state_ff.last_index   <= '0;
         state_ff.last_term    <= '0;
         state_ff.commit       <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_take) begin
            case (csr_index)
               CSR_NODE_ID:      cfg_ff.node_id            <= csr_data[7:0];
               CSR_PEER_COUNT:   cfg_ff.peer_count         <= csr_data[3:0];
               CSR_HEARTBEAT:    cfg_ff.heartbeat_interval <= csr_data;
               CSR_TIMEOUT_MIN:  cfg_ff.timeout_min        <= csr_data;
               CSR_TIMEOUT_SPAN: cfg_ff.timeout_span       <= csr_data;
               CSR_RANDOM_SEED: begin
                  cfg_ff.random_seed <= csr_data;
                  // seed write reloads the generator, zero maps to one
                  state_ff.lfsr <= (csr_data == '0) ? 16'd1 : csr_data;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_event_ff <= req_event;
      end
      if (advance) begin
         out_result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.msg_kind;
   assign rsp_tdata  = {4'd0,
                        out_result_ff.vote_holder,
                        out_result_ff.term_now,
                        out_result_ff.role,
                        out_result_ff.commit_point,
                        out_result_ff.log_term,
                        out_result_ff.log_index,
                        out_result_ff.ok,
                        out_result_ff.reply_term};
endmodule

### sv/cree_checker.sv
// port-level checks of the role election engine and their bind
module cree_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [cree_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [2:0]                         rsp_tuser
);
   import cree_pkg::*;

   logic [1:0] role_seen;
   logic [8:0] vote_seen;
   logic       ok_seen;

   assign role_seen = rsp_tdata[130:129];
   assign vote_seen = rsp_tdata[171:163];
   assign ok_seen   = rsp_tdata[32];

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // heartbeats only come from a leader
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_HEARTBEAT |-> role_seen == ROLE_LEADER)
      else $error("heartbeat without leader role");

   // a vote broadcast means candidate with a vote held
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_VOTE_BCAST |->
         role_seen == ROLE_CANDIDATE && vote_seen != 9'h1FF)
      else $error("vote broadcast without candidacy");

   // an accepted append always leaves a follower
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_APPEND_RPLY && ok_seen |-> role_seen == ROLE_FOLLOWER)
      else $error("append accepted but not follower");

   // a granted vote is held for someone
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_VOTE_REPLY && ok_seen |-> vote_seen != 9'h1FF)
      else $error("vote granted but none recorded");
endmodule

bind consensus_role_election_engine cree_checker u_cree_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
